// ===== rtl/gzhs_pkg.sv =====
// Shared types and constants for the gzip header stripper.
// Used by the front parser, the command queue, the emitter and the top level.
`timescale 1ns / 1ps

package gzhs_pkg;

    typedef enum logic [3:0] {
        PH_MAGIC    = 4'd0,
        PH_HEADER   = 4'd1,
        PH_XLEN0    = 4'd2,
        PH_XLEN1    = 4'd3,
        PH_XDATA    = 4'd4,
        PH_FNAME    = 4'd5,
        PH_FCOMMENT = 4'd6,
        PH_HCRC     = 4'd7,
        PH_PAYLOAD  = 4'd8,
        PH_RAW      = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        KIND_RAW     = 2'd0,
        KIND_DEFLATE = 2'd1,
        KIND_END     = 2'd2
    } kind_t;

    localparam logic [7:0] ID1 = 8'h1f;
    localparam logic [7:0] ID2 = 8'h8b;
    localparam logic [7:0] CM_DEFLATE = 8'h08;
    localparam logic [3:0] HEADER_LEN = 4'd10;
    localparam logic [3:0] FLAG_INDEX = 4'd3;

    localparam int FLG_FHCRC    = 1;
    localparam int FLG_FEXTRA   = 2;
    localparam int FLG_FNAME    = 3;
    localparam int FLG_FCOMMENT = 4;

    localparam int FifoDepth = 2;
    localparam int FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
    localparam int FifoCntW  = $clog2(FifoDepth + 1);

    // One command carries every result item that one input item causes.
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] bytes;
        kind_t           kind;
        logic [4:0]      flags;
        logic            last;
    } cmd_t;

endpackage

// ===== rtl/gzhs_front.sv =====
// Front parser: accepts stream bytes, tracks the header phase and builds commands.
// Depends on gzhs_pkg.
`timescale 1ns / 1ps

module gzhs_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      in_byte,
    input  logic            in_last,
    output logic            cmd_valid,
    output gzhs_pkg::cmd_t  cmd
);

    gzhs_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  held_reg [3];
    logic [1:0]  held_count_reg, held_count_next;
    logic [3:0]  header_index_reg, header_index_next;
    logic [4:0]  flag_bits_reg, flag_bits_next;
    logic [15:0] extra_reg, extra_next;
    logic [1:0]  checksum_reg, checksum_next;
    logic [1:0]  idx;
    logic        in_header;

    function automatic gzhs_pkg::phase_t advance(gzhs_pkg::phase_t from, logic [4:0] fl);
        gzhs_pkg::phase_t nxt;
        if (from < gzhs_pkg::PH_XLEN0 && fl[gzhs_pkg::FLG_FEXTRA])
            nxt = gzhs_pkg::PH_XLEN0;
        else if (from < gzhs_pkg::PH_FNAME && fl[gzhs_pkg::FLG_FNAME])
            nxt = gzhs_pkg::PH_FNAME;
        else if (from < gzhs_pkg::PH_FCOMMENT && fl[gzhs_pkg::FLG_FCOMMENT])
            nxt = gzhs_pkg::PH_FCOMMENT;
        else if (from < gzhs_pkg::PH_HCRC && fl[gzhs_pkg::FLG_FHCRC])
            nxt = gzhs_pkg::PH_HCRC;
        else
            nxt = gzhs_pkg::PH_PAYLOAD;
        return nxt;
    endfunction

    assign idx = (held_count_reg > 2'd2) ? 2'd2 : held_count_reg;

    always_comb
    begin
        phase_next        = phase_reg;
        held_count_next   = held_count_reg;
        header_index_next = header_index_reg;
        flag_bits_next    = flag_bits_reg;
        extra_next        = extra_reg;
        checksum_next     = checksum_reg;
        in_header         = 1'b0;
        cmd               = '0;
        cmd.kind          = gzhs_pkg::KIND_RAW;
        cmd.last          = in_last;
        cmd.bytes[0]      = in_byte;
        case (phase_reg)
            gzhs_pkg::PH_MAGIC:
            begin
                held_count_next = idx + 2'd1;
                cmd.bytes[0] = (idx == 2'd0) ? in_byte : held_reg[0];
                cmd.bytes[1] = (idx == 2'd1) ? in_byte : held_reg[1];
                cmd.bytes[2] = in_byte;
                if (idx == 2'd2)
                begin
                    if (held_reg[0] == gzhs_pkg::ID1 && held_reg[1] == gzhs_pkg::ID2 &&
                        in_byte == gzhs_pkg::CM_DEFLATE)
                    begin
                        phase_next        = gzhs_pkg::PH_HEADER;
                        header_index_next = gzhs_pkg::FLAG_INDEX;
                        flag_bits_next    = '0;
                        in_header         = 1'b1;
                    end
                    else
                    begin
                        cmd.cnt    = 2'd3;
                        phase_next = gzhs_pkg::PH_RAW;
                    end
                end
                else if (in_last)
                begin
                    cmd.cnt = idx + 2'd1;
                end
            end
            gzhs_pkg::PH_HEADER:
            begin
                in_header = 1'b1;
                if (header_index_reg == gzhs_pkg::FLAG_INDEX)
                    flag_bits_next = in_byte[4:0];
                header_index_next = header_index_reg + 4'd1;
                if (header_index_next >= gzhs_pkg::HEADER_LEN ||
                    header_index_next < gzhs_pkg::FLAG_INDEX)
                    phase_next = advance(gzhs_pkg::PH_HEADER, flag_bits_next);
            end
            gzhs_pkg::PH_XLEN0:
            begin
                in_header  = 1'b1;
                extra_next = {8'd0, in_byte};
                phase_next = gzhs_pkg::PH_XLEN1;
            end
            gzhs_pkg::PH_XLEN1:
            begin
                in_header  = 1'b1;
                extra_next = {in_byte, extra_reg[7:0]};
                phase_next = (extra_next == 16'd0) ?
                             advance(gzhs_pkg::PH_XDATA, flag_bits_reg) : gzhs_pkg::PH_XDATA;
            end
            gzhs_pkg::PH_XDATA:
            begin
                in_header  = 1'b1;
                extra_next = extra_reg - 16'd1;
                if (extra_next == 16'd0)
                    phase_next = advance(gzhs_pkg::PH_XDATA, flag_bits_reg);
            end
            gzhs_pkg::PH_FNAME, gzhs_pkg::PH_FCOMMENT:
            begin
                in_header = 1'b1;
                if (in_byte == 8'd0)
                    phase_next = advance(phase_reg, flag_bits_reg);
            end
            gzhs_pkg::PH_HCRC:
            begin
                in_header     = 1'b1;
                checksum_next = checksum_reg + 2'd1;
                if (checksum_next >= 2'd2)
                    phase_next = gzhs_pkg::PH_PAYLOAD;
            end
            gzhs_pkg::PH_PAYLOAD:
            begin
                cmd.cnt   = 2'd1;
                cmd.kind  = gzhs_pkg::KIND_DEFLATE;
                cmd.flags = flag_bits_reg;
            end
            default:
            begin
                cmd.cnt = 2'd1;
            end
        endcase

        if (phase_next == gzhs_pkg::PH_HCRC && phase_reg != gzhs_pkg::PH_HCRC)
            checksum_next = '0;

        if (in_last)
        begin
            if (in_header)
            begin
                cmd.cnt      = 2'd1;
                cmd.bytes    = '0;
                cmd.kind     = gzhs_pkg::KIND_END;
                cmd.flags    = flag_bits_next;
            end
            phase_next        = gzhs_pkg::PH_MAGIC;
            held_count_next   = '0;
            header_index_next = '0;
            flag_bits_next    = '0;
            extra_next        = '0;
            checksum_next     = '0;
        end
    end

    assign cmd_valid = accept && (cmd.cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= gzhs_pkg::PH_MAGIC;
            held_count_reg   <= '0;
            header_index_reg <= '0;
            flag_bits_reg    <= '0;
            extra_reg        <= '0;
            checksum_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            held_count_reg   <= held_count_next;
            header_index_reg <= header_index_next;
            flag_bits_reg    <= flag_bits_next;
            extra_reg        <= extra_next;
            checksum_reg     <= checksum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && phase_reg == gzhs_pkg::PH_MAGIC)
            held_reg[idx] <= in_byte;
    end

endmodule

// ===== rtl/gzhs_fifo.sv =====
// Short command queue between the front parser and the emitter.
// Depends on gzhs_pkg for the command type and depth.
`timescale 1ns / 1ps

module gzhs_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  gzhs_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output gzhs_pkg::cmd_t  head
);

    gzhs_pkg::cmd_t mem_reg [gzhs_pkg::FifoDepth];
    logic [gzhs_pkg::FifoPtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [gzhs_pkg::FifoPtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [gzhs_pkg::FifoCntW-1:0] count_reg, count_next;

    localparam logic [gzhs_pkg::FifoPtrW-1:0] LastPtr = gzhs_pkg::FifoPtrW'(gzhs_pkg::FifoDepth - 1);
    localparam logic [gzhs_pkg::FifoCntW-1:0] FullCount = gzhs_pkg::FifoCntW'(gzhs_pkg::FifoDepth);

    assign full      = (count_reg == FullCount);
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== rtl/gzhs_back.sv =====
// Emitter: sends queued commands' items one per cycle while m_tready is high.
// Depends on gzhs_pkg.
`timescale 1ns / 1ps

module gzhs_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_avail,
    input  gzhs_pkg::cmd_t  cmd_head,
    output logic            cmd_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic [6:0]      m_tuser,
    output logic            m_tlast
);

    gzhs_pkg::cmd_t cur_reg;
    logic           cur_valid_reg;
    logic [1:0]     idx_reg, idx_next;
    logic           fire;
    logic           at_end;
    logic [7:0]     sel_byte;

    assign fire    = cur_valid_reg && m_tready;
    assign at_end  = (idx_reg == cur_reg.cnt - 2'd1);
    assign cmd_pop = cmd_avail && (!cur_valid_reg || (fire && at_end));

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd_pop)
            idx_next = '0;
        else if (fire && !at_end)
            idx_next = idx_reg + 2'd1;
    end

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = cur_reg.bytes[0];
            2'd1:    sel_byte = cur_reg.bytes[1];
            default: sel_byte = cur_reg.bytes[2];
        endcase
    end

    assign m_tvalid = cur_valid_reg;
    assign m_tdata  = sel_byte;
    assign m_tuser  = {cur_reg.flags, 2'(cur_reg.kind)};
    assign m_tlast  = cur_reg.last && at_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd_pop)
                cur_valid_reg <= 1'b1;
            else if (fire && at_end)
                cur_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
            cur_reg <= cmd_head;
    end

endmodule

// ===== rtl/gzip_header_stripper.sv =====
// Top level of the gzip header stripper: front parser, command queue and emitter.
// Depends on gzhs_pkg, gzhs_front, gzhs_fifo and gzhs_back.
`timescale 1ns / 1ps
//
// Bytes enter on the s_ group, one item per handshake, with s_tlast on the
// final byte of a stream. Results leave on the m_ group: m_tdata is the byte,
// m_tuser carries the kind (raw, deflate payload or end marker) and the kept
// gzip flags, and m_tlast closes the stream.
// The front parser classifies each accepted byte in the cycle it arrives and
// writes at most one command, holding up to three result items, to a two-entry
// queue. The emitter sends one item per cycle from its output register while
// the receiver is ready. The first result of a byte goes through a queue entry
// and then the output register. Sustained throughput is one byte per cycle
// while the receiver is ready; the three replayed bytes of a failed ID check
// go one per cycle. Header bytes yield no items, save an end marker on s_tlast.
// Reset clears the parser to the ID check and empties the queue and the
// output register. When the receiver stalls, the output item holds, the queue
// fills, and s_tready drops once both queue entries are taken.

module gzip_header_stripper
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte[7:0]
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte[7:0]
    output logic [6:0] m_tuser,   // payload_kind[1:0], header_flags[6:2]
    output logic       m_tlast
);

    logic           accept;
    logic           cmd_valid;
    gzhs_pkg::cmd_t cmd;
    logic           fifo_full;
    logic           fifo_not_empty;
    gzhs_pkg::cmd_t fifo_head;
    logic           fifo_pop;

    assign s_tready = !fifo_full;
    assign accept   = s_tvalid && s_tready;

    gzhs_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    gzhs_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_valid),
        .push_cmd  (cmd),
        .pop       (fifo_pop),
        .full      (fifo_full),
        .not_empty (fifo_not_empty),
        .head      (fifo_head)
    );

    gzhs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_avail (fifo_not_empty),
        .cmd_head  (fifo_head),
        .cmd_pop   (fifo_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> !fifo_full)
        else $error("Command written into a full queue.");

    a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1:0] == gzhs_pkg::KIND_END) |-> (m_tlast && m_tdata == 8'd0))
        else $error("End marker without last flag or with data.");

    a_raw_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1:0] == gzhs_pkg::KIND_RAW) |-> (m_tuser[6:2] == 5'd0))
        else $error("Raw item carries header flags.");

    a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_pop |-> fifo_not_empty)
        else $error("Queue read while empty.");

endmodule
